// ===== rtl/core/sasl_pkg.sv =====
// Shared types, widths, request codes and reset values for the servo slew limiter.
`default_nettype none

package sasl_pkg;

    localparam int ANGLE_W    = 8;
    localparam int PULSE_W    = 12;
    localparam int INTERVAL_W = 10;
    localparam int PROD_W     = ANGLE_W + PULSE_W;
    localparam int CH_PORT_W  = 2;
    localparam int REQ_W      = 2;
    localparam int CFG_IDX_W  = 2;

    localparam int CHANNELS_DEF = 2;

    localparam logic [ANGLE_W-1:0]    MAX_DEG          = 8'd180;
    localparam logic [PULSE_W-1:0]    PULSE_MIN_RST    = 12'd500;
    localparam logic [PULSE_W-1:0]    PULSE_MAX_RST    = 12'd2500;
    localparam logic [INTERVAL_W-1:0] RAMP_INTERVAL_RST = 10'd20;
    localparam logic [ANGLE_W-1:0]    RAMP_STEP_RST    = 8'd1;

    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PINCH = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 2'd3;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] product;
    } mul_res_t;

    typedef struct packed {
        logic               done;
        logic [PULSE_W-1:0] quotient;
    } div_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/sasl_mul.sv =====
// Bit-serial shift-and-add multiplier: angle times pulse span, one angle bit per cycle.
`default_nettype none

module sasl_mul (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [sasl_pkg::ANGLE_W-1:0] mplier,
    input  wire logic [sasl_pkg::PULSE_W-1:0] mcand,
    output sasl_pkg::mul_res_t                res
);

    localparam int CNT_W = $clog2(sasl_pkg::ANGLE_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [sasl_pkg::PROD_W-1:0]  acc_reg, acc_next;
    logic [sasl_pkg::PROD_W-1:0]  cand_reg, cand_next;
    logic [sasl_pkg::ANGLE_W-1:0] plier_reg, plier_next;

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        cand_next  = cand_reg;
        plier_next = plier_reg;
        if (start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            acc_next   = '0;
            cand_next  = sasl_pkg::PROD_W'(mcand);
            plier_next = mplier;
        end else if (busy_reg) begin
            if (plier_reg[0]) begin
                acc_next = acc_reg + cand_reg;
            end
            cand_next  = {cand_reg[sasl_pkg::PROD_W-2:0], 1'b0};
            plier_next = {1'b0, plier_reg[sasl_pkg::ANGLE_W-1:1]};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(sasl_pkg::ANGLE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg   <= acc_next;
        cand_reg  <= cand_next;
        plier_reg <= plier_next;
    end

    assign res.done    = done_reg;
    assign res.product = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sasl_div.sv =====
// Bit-serial restoring divider by 180, one quotient bit per cycle.
`default_nettype none

module sasl_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [sasl_pkg::PROD_W-1:0] dividend,
    output sasl_pkg::div_res_t               res
);

    localparam int CNT_W = $clog2(sasl_pkg::PROD_W);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic [sasl_pkg::PROD_W-1:0]  dvd_reg, dvd_next;
    logic [sasl_pkg::ANGLE_W-1:0] rem_reg, rem_next;
    logic [sasl_pkg::PULSE_W-1:0] quo_reg, quo_next;
    logic [sasl_pkg::ANGLE_W:0]   trial;
    logic                         fits;

    assign trial = {rem_reg, dvd_reg[sasl_pkg::PROD_W-1]};
    assign fits  = trial >= {1'b0, sasl_pkg::MAX_DEG};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next = fits ? sasl_pkg::ANGLE_W'(trial - {1'b0, sasl_pkg::MAX_DEG})
                            : trial[sasl_pkg::ANGLE_W-1:0];
            quo_next = {quo_reg[sasl_pkg::PULSE_W-2:0], fits};
            dvd_next = {dvd_reg[sasl_pkg::PROD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(sasl_pkg::PROD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign res.done     = done_reg;
    assign res.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/servo_angle_slew_limiter.sv =====
// Top level of the multi-channel servo angle slew limiter.
//
//  channel  | direction | ports
//  ---------+-----------+-----------------------------------------------------------
//  s_       | in        | s_valid s_ready s_req_type s_channel s_angle_deg
//  m_       | out       | m_valid m_ready m_out_channel m_current_deg m_target_deg
//           |           | m_pulse_us m_moved m_last_of_run
//  cfg_     | in        | cfg_valid cfg_ready cfg_index cfg_data
//
// A set-target or pinch-relief word visits the update state; a tick with no ramp step stays idle.
// A ramp step visits each channel in turn: the move, then the serial multiplier, then the
// serial divider by 180. The emit state after them loads the output register, and it
// waits while a result stalls.
// Reset is synchronous and active low; it clears the angles and the tick count and
// restores the configuration registers to their defaults.
// A word on the input may be taken while the last result still waits on the output.
`default_nettype none

module servo_angle_slew_limiter #(
    parameter int CHANNELS = sasl_pkg::CHANNELS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [sasl_pkg::REQ_W-1:0]     s_req_type,
    input  wire logic [sasl_pkg::CH_PORT_W-1:0] s_channel,
    input  wire logic [sasl_pkg::ANGLE_W-1:0]   s_angle_deg,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [sasl_pkg::CH_PORT_W-1:0]      m_out_channel,
    output logic [sasl_pkg::ANGLE_W-1:0]        m_current_deg,
    output logic [sasl_pkg::ANGLE_W-1:0]        m_target_deg,
    output logic [sasl_pkg::PULSE_W-1:0]        m_pulse_us,
    output logic                                m_moved,
    output logic                                m_last_of_run,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sasl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [sasl_pkg::PULSE_W-1:0]   cfg_data
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW   = sasl_pkg::ANGLE_W;
    localparam int PW   = sasl_pkg::PULSE_W;
    localparam int IW   = sasl_pkg::INTERVAL_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_UPD  = 6'b000010,
        ST_CALC = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_DIV  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [PW-1:0]   pmin_reg, pmax_reg;
    logic [IW-1:0]   interval_reg, ms_reg, ms_next, ms_inc;
    logic [AW-1:0]   step_reg;
    logic [AW-1:0]   cur_reg [CHANNELS];
    logic [AW-1:0]   tgt_reg [CHANNELS];
    logic [CH_W-1:0] idx_reg, idx_next;
    logic [sasl_pkg::REQ_W-1:0] req_reg, req_next;
    logic [AW-1:0]   deg_reg, deg_next;

    logic [AW-1:0]   res_cur_reg, res_cur_next;
    logic [AW-1:0]   res_tgt_reg, res_tgt_next;
    logic            res_moved_reg, res_moved_next;
    logic [PW-1:0]   pulse_reg, pulse_next;

    logic            m_valid_reg, m_valid_next;
    logic [sasl_pkg::CH_PORT_W-1:0] m_ch_reg;
    logic [AW-1:0]   m_cur_reg, m_tgt_reg;
    logic [PW-1:0]   m_pulse_reg;
    logic            m_moved_reg, m_last_reg;
    logic            m_load;

    logic            s_fire, ch_ok, is_last;
    logic [AW-1:0]   cur_sel, tgt_sel, ang_next, gap_deg, upd_tgt;
    logic [AW:0]     back_sum;
    logic            wr_cur, wr_tgt;
    logic            span_up;
    logic [PW-1:0]   span;
    logic            mul_start, div_start;
    sasl_pkg::mul_res_t mul_res;
    sasl_pkg::div_res_t div_res;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign ch_ok     = {1'b0, s_channel} < 3'(CHANNELS);
    assign is_last   = (idx_reg == CH_W'(CHANNELS - 1));
    assign cur_sel   = cur_reg[idx_reg];
    assign tgt_sel   = tgt_reg[idx_reg];
    assign ms_inc    = ms_reg + 1'b1;
    assign span_up   = (pmax_reg >= pmin_reg);
    assign span      = span_up ? (pmax_reg - pmin_reg) : (pmin_reg - pmax_reg);
    assign back_sum  = {1'b0, cur_sel} + {1'b0, deg_reg};

    // Ramp move: step toward the target, snapping once within one step.
    always_comb begin
        ang_next = cur_sel;
        gap_deg  = '0;
        if (tgt_sel > cur_sel) begin
            gap_deg  = tgt_sel - cur_sel;
            ang_next = (gap_deg > step_reg) ? (cur_sel + step_reg) : tgt_sel;
        end else if (tgt_sel < cur_sel) begin
            gap_deg  = cur_sel - tgt_sel;
            ang_next = (gap_deg > step_reg) ? (cur_sel - step_reg) : tgt_sel;
        end
    end

    // Target update for set-target and pinch-relief words.
    always_comb begin
        upd_tgt = tgt_sel;
        case (req_reg)
            sasl_pkg::REQ_SET: begin
                upd_tgt = (deg_reg > sasl_pkg::MAX_DEG) ? sasl_pkg::MAX_DEG : deg_reg;
            end
            sasl_pkg::REQ_PINCH: begin
                if (tgt_sel >= cur_sel) begin
                    upd_tgt = (deg_reg >= cur_sel) ? '0 : (cur_sel - deg_reg);
                end else begin
                    upd_tgt = (back_sum > {1'b0, sasl_pkg::MAX_DEG}) ? sasl_pkg::MAX_DEG
                                                                      : back_sum[AW-1:0];
                end
            end
            default: begin
                upd_tgt = tgt_sel;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        req_next       = req_reg;
        deg_next       = deg_reg;
        ms_next        = ms_reg;
        res_cur_next   = res_cur_reg;
        res_tgt_next   = res_tgt_reg;
        res_moved_next = res_moved_reg;
        pulse_next     = pulse_reg;
        wr_cur         = 1'b0;
        wr_tgt         = 1'b0;
        mul_start      = 1'b0;
        div_start      = 1'b0;
        m_load         = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    req_next = s_req_type;
                    deg_next = s_angle_deg;
                    idx_next = s_channel[CH_W-1:0];
                    if (s_req_type == sasl_pkg::REQ_TICK) begin
                        idx_next = '0;
                        if (ms_inc >= interval_reg) begin
                            ms_next    = '0;
                            state_next = ST_CALC;
                        end else begin
                            ms_next = ms_inc;
                        end
                    end else if ((s_req_type == sasl_pkg::REQ_SET ||
                                  s_req_type == sasl_pkg::REQ_PINCH) && ch_ok) begin
                        state_next = ST_UPD;
                    end
                end
            end
            ST_UPD: begin
                wr_tgt     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_CALC: begin
                wr_cur         = 1'b1;
                res_cur_next   = ang_next;
                res_tgt_next   = tgt_sel;
                res_moved_next = (ang_next != cur_sel);
                mul_start      = 1'b1;
                state_next     = ST_MUL;
            end
            ST_MUL: begin
                if (mul_res.done) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    pulse_next = span_up ? (pmin_reg + div_res.quotient)
                                         : (pmin_reg - div_res.quotient);
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    m_load = 1'b1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_CALC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid_next = m_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            ms_reg       <= '0;
            m_valid_reg  <= 1'b0;
            pmin_reg     <= sasl_pkg::PULSE_MIN_RST;
            pmax_reg     <= sasl_pkg::PULSE_MAX_RST;
            interval_reg <= sasl_pkg::RAMP_INTERVAL_RST;
            step_reg     <= sasl_pkg::RAMP_STEP_RST;
            for (int i = 0; i < CHANNELS; i++) begin
                cur_reg[i] <= '0;
                tgt_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            ms_reg      <= ms_next;
            m_valid_reg <= m_valid_next;
            if (wr_cur) begin
                cur_reg[idx_reg] <= ang_next;
            end
            if (wr_tgt) begin
                tgt_reg[idx_reg] <= upd_tgt;
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    sasl_pkg::CFG_PULSE_MIN: pmin_reg <= cfg_data;
                    sasl_pkg::CFG_PULSE_MAX: pmax_reg <= cfg_data;
                    sasl_pkg::CFG_INTERVAL:  interval_reg <= cfg_data[IW-1:0];
                    sasl_pkg::CFG_STEP:      step_reg <= cfg_data[AW-1:0];
                    default: begin
                    end
                endcase
            end
        end
        req_reg       <= req_next;
        deg_reg       <= deg_next;
        res_cur_reg   <= res_cur_next;
        res_tgt_reg   <= res_tgt_next;
        res_moved_reg <= res_moved_next;
        pulse_reg     <= pulse_next;
        if (m_load) begin
            m_ch_reg    <= sasl_pkg::CH_PORT_W'(idx_reg);
            m_cur_reg   <= res_cur_reg;
            m_tgt_reg   <= res_tgt_reg;
            m_pulse_reg <= pulse_reg;
            m_moved_reg <= res_moved_reg;
            m_last_reg  <= is_last;
        end
    end

    sasl_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mplier  (ang_next),
        .mcand   (span),
        .res     (mul_res)
    );

    sasl_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mul_res.product),
        .res      (div_res)
    );

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_ch_reg;
    assign m_current_deg = m_cur_reg;
    assign m_target_deg  = m_tgt_reg;
    assign m_pulse_us    = m_pulse_reg;
    assign m_moved       = m_moved_reg;
    assign m_last_of_run = m_last_reg;

    // Angles never leave the servo's travel range.
    for (genvar g = 0; g < CHANNELS; g++) begin : g_range_chk
        a_cur_range: assert property (@(posedge aclk) disable iff (!aresetn)
            cur_reg[g] <= sasl_pkg::MAX_DEG)
            else $error("current angle beyond 180 degrees");
        a_tgt_range: assert property (@(posedge aclk) disable iff (!aresetn)
            tgt_reg[g] <= sasl_pkg::MAX_DEG)
            else $error("target angle beyond 180 degrees");
    end

    // A freshly loaded pulse width lies between the two pulse limits.
    a_pulse_span: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |->
            ((m_pulse_reg >= pmin_reg && m_pulse_reg <= pmax_reg) ||
             (m_pulse_reg <= pmin_reg && m_pulse_reg >= pmax_reg)))
        else $error("pulse width outside the configured limits");

endmodule

`default_nettype wire
